// File: sv/error_diffusion_dither_defines.svh
// ----------------------------------------------------------------------------
// Error diffusion dither - assertion macros
// Property wrappers for the checks in the dither back end.
// ----------------------------------------------------------------------------
`ifndef ERROR_DIFFUSION_DITHER_DEFINES_SVH
`define ERROR_DIFFUSION_DITHER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define EDD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("dither check failed");

// Next-cycle implication, disabled while in reset
`define EDD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("dither check failed");

`endif

// File: sv/edd_pkg.sv
// ----------------------------------------------------------------------------
// Error diffusion dither - package
// Sizes, queue word type, register codes and the error share helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package edd_pkg;

  // Frame limits
  localparam int MaxWidth  = 2048;
  localparam int MaxHeight = 2048;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);

  // Field widths
  localparam int DimW = 12;
  localparam int ThrW = 8;
  localparam int PixW = 8;
  localparam int ErrW = 9;

  // Front/back queue
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);

  // Register reset values
  localparam logic [DimW-1:0] LineWidthRst   = DimW'(1280);
  localparam logic [DimW-1:0] FrameHeightRst = DimW'(720);
  localparam logic [ThrW-1:0] ThresholdRst   = ThrW'(127);

  // Diffusion weights, sixteenths
  localparam logic [2:0] WtRight     = 3'd7;
  localparam logic [2:0] WtBelowLeft = 3'd3;
  localparam logic [2:0] WtBelow     = 3'd5;
  localparam logic [2:0] WtBelowRght = 3'd1;

  // Register map indices
  typedef enum logic [1:0] {
    RegLineWidth   = 2'd0,
    RegFrameHeight = 2'd1,
    RegThreshold   = 2'd2
  } edd_reg_e;

  typedef logic signed [ErrW-1:0] edd_err_t;

  // Classified pixel word passed from front to back
  typedef struct packed {
    logic [PixW-1:0] gray_pixel;
    logic [ColW-1:0] col;
    logic            first_row;
    logic            eol;
    logic            eof;
  } edd_item_t;

  // e * wt / 16, truncating toward zero
  function automatic edd_err_t edd_share(input edd_err_t e, input logic [2:0] wt);
    logic signed [11:0] prod;
    logic signed [11:0] adj;
    prod = 12'(e) * $signed({9'b0, wt});
    adj  = prod + (prod[11] ? 12'sd15 : 12'sd0);
    return {adj[11], adj[11:4]};
  endfunction

endpackage

// File: sv/edd_if.sv
// ----------------------------------------------------------------------------
// Error diffusion dither - stream interfaces
// Valid/ready channels for gray pixels in and dithered pixels out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Gray pixel channel
interface edd_pix_if;
  logic                      valid;
  logic                      ready;
  logic [edd_pkg::PixW-1:0]  gray_pixel;

  modport source (output valid, output gray_pixel, input ready);
  modport sink   (input valid, input gray_pixel, output ready);
endinterface

// Dithered pixel channel
interface edd_dot_if;
  logic valid;
  logic ready;
  logic white;
  logic end_of_line;
  logic end_of_frame;

  modport source (output valid, output white, output end_of_line, output end_of_frame,
                  input ready);
  modport sink   (input valid, input white, input end_of_line, input end_of_frame,
                  output ready);
endinterface

// File: sv/edd_front.sv
// ----------------------------------------------------------------------------
// Error diffusion dither - front end
// Takes gray pixels, tracks raster position and tags row/frame ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edd_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  edd_pix_if.sink                     pix_i,
  input  logic [edd_pkg::DimW-1:0]    line_width_i,
  input  logic [edd_pkg::DimW-1:0]    frame_height_i,
  input  logic                        full_i,
  output logic                        push_o,
  output edd_pkg::edd_item_t          item_o
);

  localparam logic [edd_pkg::DimW:0] MaxW = (edd_pkg::DimW + 1)'(edd_pkg::MaxWidth);
  localparam logic [edd_pkg::DimW:0] MaxH = (edd_pkg::DimW + 1)'(edd_pkg::MaxHeight);

  logic [edd_pkg::ColW-1:0] col_q, col_d;
  logic [edd_pkg::RowW-1:0] row_q, row_d;
  logic [edd_pkg::DimW:0]   width, height;
  logic                     eol, eof;

  // Effective frame size, clamped to the legal range
  always_comb begin
    width  = {1'b0, line_width_i};
    height = {1'b0, frame_height_i};
    if (width < (edd_pkg::DimW + 1)'(2)) width = (edd_pkg::DimW + 1)'(2);
    else if (width > MaxW) width = MaxW;
    if (height == '0) height = (edd_pkg::DimW + 1)'(1);
    else if (height > MaxH) height = MaxH;
  end

  assign eol = ((edd_pkg::DimW + 1)'(col_q) + 1'b1) >= width;
  assign eof = eol && (((edd_pkg::DimW + 1)'(row_q) + 1'b1) >= height);

  // Accept whenever the queue has room
  assign pix_i.ready = !full_i;
  assign push_o      = pix_i.valid && !full_i;

  assign item_o.gray_pixel = pix_i.gray_pixel;
  assign item_o.col        = col_q;
  assign item_o.first_row  = (row_q == '0);
  assign item_o.eol        = eol;
  assign item_o.eof        = eof;

  // Raster position
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (push_o) begin
      if (eol) begin
        col_d = '0;
        row_d = eof ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// File: sv/edd_fifo.sv
// ----------------------------------------------------------------------------
// Error diffusion dither - word queue
// Short first-in first-out queue that decouples front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edd_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  edd_pkg::edd_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output edd_pkg::edd_item_t item_o
);

  edd_pkg::edd_item_t          slot_q [edd_pkg::FifoDepth];
  logic [edd_pkg::FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [edd_pkg::FifoPtrW:0]   count_q;

  assign full_o  = (count_q == (edd_pkg::FifoPtrW + 1)'(edd_pkg::FifoDepth));
  assign empty_o = (count_q == '0);
  assign item_o  = slot_q[rd_ptr_q];

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= item_i;
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// File: sv/edd_back.sv
// ----------------------------------------------------------------------------
// Error diffusion dither - back end
// Line error buffer, quantiser and error diffusion, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "error_diffusion_dither_defines.svh"

module edd_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     empty_i,
  input  edd_pkg::edd_item_t       head_i,
  output logic                     pop_o,
  input  logic [edd_pkg::ThrW-1:0] threshold_i,
  edd_dot_if.source                dot_o
);

  // Line error buffer, one entry per column
  logic [edd_pkg::ErrW-1:0] line_mem [edd_pkg::MaxWidth];
  logic [edd_pkg::ErrW-1:0] rd_data_q;
  logic                     byp_hit_q;
  edd_pkg::edd_err_t        byp_data_q;

  // Working stage
  logic               b_valid_q;
  edd_pkg::edd_item_t b_item_q;
  logic               b_fire;

  // Carried errors
  edd_pkg::edd_err_t rc_q, pbl_q, pb_q;

  // Deferred write of the last column's error
  logic                     eol_wr_q;
  logic [edd_pkg::ColW-1:0] eol_addr_q;
  edd_pkg::edd_err_t        eol_data_q;

  // Output register
  logic out_valid_q, out_white_q, out_eol_q, out_eof_q;

  // Datapath
  edd_pkg::edd_err_t        above, e, sh7, sh3, sh5, sh1;
  logic signed [10:0]       sum;
  logic [edd_pkg::PixW-1:0] level;
  logic                     white;

  // Write port
  logic                     wr_en;
  logic [edd_pkg::ColW-1:0] wr_addr;
  edd_pkg::edd_err_t        wr_data;

  assign b_fire = b_valid_q && (!out_valid_q || dot_o.ready);
  assign pop_o  = !empty_i && (!b_valid_q || b_fire);

  // Error from the row above; first row takes none
  always_comb begin
    if (b_item_q.first_row) above = '0;
    else if (byp_hit_q)     above = byp_data_q;
    else                    above = $signed(rd_data_q);
  end

  // Adjust, clamp, quantise
  always_comb begin
    sum = $signed({3'b0, b_item_q.gray_pixel}) + 11'(rc_q) + 11'(above);
    if (sum[10])             level = '0;
    else if (sum > 11'sd255) level = '1;
    else                     level = sum[7:0];
    white = level > threshold_i;
    e     = $signed({1'b0, level}) - (white ? 9'sd255 : 9'sd0);
    sh7   = edd_pkg::edd_share(e, edd_pkg::WtRight);
    sh3   = edd_pkg::edd_share(e, edd_pkg::WtBelowLeft);
    sh5   = edd_pkg::edd_share(e, edd_pkg::WtBelow);
    sh1   = edd_pkg::edd_share(e, edd_pkg::WtBelowRght);
  end

  // A pixel after a row end has column zero and never writes, so the
  // deferred word always finds the port free
  always_comb begin
    wr_en   = (b_fire && (b_item_q.col != '0)) || eol_wr_q;
    wr_addr = eol_wr_q ? eol_addr_q : b_item_q.col - 1'b1;
    wr_data = eol_wr_q ? eol_data_q : pbl_q + sh3;
  end

  // Buffer memory: registered read on pop, write-through bypass
  always_ff @(posedge clk_i) begin
    if (wr_en) line_mem[wr_addr] <= wr_data;
    if (pop_o) begin
      rd_data_q  <= line_mem[head_i.col];
      byp_data_q <= wr_data;
    end
  end

  // Stage and carried state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      byp_hit_q <= 1'b0;
      rc_q      <= '0;
      pbl_q     <= '0;
      pb_q      <= '0;
      eol_wr_q  <= 1'b0;
    end else begin
      if (pop_o)       b_valid_q <= 1'b1;
      else if (b_fire) b_valid_q <= 1'b0;
      if (pop_o) byp_hit_q <= wr_en && (wr_addr == head_i.col);
      eol_wr_q <= b_fire && b_item_q.eol;
      if (b_fire) begin
        if (b_item_q.eol) begin
          rc_q  <= '0;
          pbl_q <= '0;
          pb_q  <= '0;
        end else begin
          rc_q  <= sh7;
          pbl_q <= pb_q + sh5;
          pb_q  <= sh1;
        end
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (pop_o) b_item_q <= head_i;
    if (b_fire) begin
      eol_addr_q <= b_item_q.col;
      eol_data_q <= pb_q + sh5;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (b_fire)           out_valid_q <= 1'b1;
      else if (dot_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fire) begin
      out_white_q <= white;
      out_eol_q   <= b_item_q.eol;
      out_eof_q   <= b_item_q.eof;
    end
  end

  assign dot_o.valid        = out_valid_q;
  assign dot_o.white        = out_white_q;
  assign dot_o.end_of_line  = out_eol_q;
  assign dot_o.end_of_frame = out_eof_q;

  // Checks
  `EDD_ASSERT_IMPL(a_wr_port_free, clk_i, rst_ni, eol_wr_q, !(b_fire && (b_item_q.col != '0)))
  `EDD_ASSERT_NEXT(a_eol_flush, clk_i, rst_ni, b_fire && b_item_q.eol, eol_wr_q && wr_en)
  `EDD_ASSERT_IMPL(a_row_start_clear, clk_i, rst_ni, b_valid_q && (b_item_q.col == '0), (rc_q == '0) && (pbl_q == '0) && (pb_q == '0))

endmodule

// File: sv/error_diffusion_dither.sv
// ----------------------------------------------------------------------------
// Error diffusion dither - top level
// Gray pixels in raster order to black/white pixels, error diffused.
//
//   channel  | dir | word                                  | handshake
//   pix_i    | in  | gray_pixel[7:0]                       | valid/ready
//   dot_o    | out | white, end_of_line, end_of_frame      | valid/ready
//   apb      | in  | line_width, frame_height, threshold   | psel/penable
//
// Sustained rate is one pixel per clock while the output is ready; the
// error loop closes in the back stage; the buffer has one read and one
// write port. A pixel passes the queue, back stage and output register.
// Reset clears position, carried errors and queue; the line buffer needs
// no clearing since the first row never reads it. A stalled output holds
// its word while the queue keeps taking pixels until it fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module error_diffusion_dither (
  input  logic        clk_i,
  input  logic        rst_ni,
  edd_pix_if.sink     pix_i,
  edd_dot_if.source   dot_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [edd_pkg::DimW-1:0] line_width_q, frame_height_q;
  logic [edd_pkg::ThrW-1:0] threshold_q;
  edd_pkg::edd_reg_e        reg_sel;
  logic                     cfg_wr;

  logic               push, full, pop, empty;
  edd_pkg::edd_item_t push_item, head_item;

  // Register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = edd_pkg::edd_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= edd_pkg::LineWidthRst;
      frame_height_q <= edd_pkg::FrameHeightRst;
      threshold_q    <= edd_pkg::ThresholdRst;
    end else if (cfg_wr) begin
      case (reg_sel)
        edd_pkg::RegLineWidth:   line_width_q   <= pwdata[edd_pkg::DimW-1:0];
        edd_pkg::RegFrameHeight: frame_height_q <= pwdata[edd_pkg::DimW-1:0];
        edd_pkg::RegThreshold:   threshold_q    <= pwdata[edd_pkg::ThrW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      edd_pkg::RegLineWidth:   prdata = 32'(line_width_q);
      edd_pkg::RegFrameHeight: prdata = 32'(frame_height_q);
      edd_pkg::RegThreshold:   prdata = 32'(threshold_q);
      default:                 prdata = '0;
    endcase
  end

  edd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pix_i          (pix_i),
    .line_width_i   (line_width_q),
    .frame_height_i (frame_height_q),
    .full_i         (full),
    .push_o         (push),
    .item_o         (push_item)
  );

  edd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (head_item)
  );

  edd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head_item),
    .pop_o       (pop),
    .threshold_i (threshold_q),
    .dot_o       (dot_o)
  );

endmodule
